[hw/rtl/assert_macros.svh]
// assertion macros used by the scheduler core rtl
// no dependencies; simulation builds get checks, synthesis builds get empty bodies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_PROP(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition seen");

`else

`define ASSERT_PROP(lbl, clk, rst_n, prop)

`define ASSERT_NEVER(lbl, clk, rst_n, expr)

`endif

`endif

[hw/rtl/dss_pkg.sv]
// types, sizes and helpers of the deferred step scheduler
// no dependencies; used by every module of the block
package dss_pkg;

    localparam int ORDER_DEPTH = 256;
    localparam int DEFER_DEPTH = 16;

    localparam int ORD_W  = $clog2(ORDER_DEPTH);
    localparam int LIM_W  = ORD_W + 1;
    localparam int DCNT_W = $clog2(DEFER_DEPTH + 1);

    typedef enum logic [1:0] {
        OP_NEXT        = 2'd0,
        OP_DEFER       = 2'd1,
        OP_RETIRE      = 2'd2,
        OP_DEFER_BELOW = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } state_t;

    localparam logic CFG_STEP_LIMIT    = 1'b0;
    localparam logic CFG_TRACKED_COUNT = 1'b1;

    typedef struct packed {
        logic             commit;
        logic             is_next;
        logic             is_retire;
        logic             do_mark;
        logic             do_append;
        logic             append_mark;
        logic [ORD_W-1:0] ord;
        logic [LIM_W-1:0] tracked;
    } cell_ctrl_t;

    function automatic logic [LIM_W-1:0] clamp_depth(input logic [LIM_W-1:0] v);
        logic [LIM_W-1:0] top;
        top = LIM_W'(ORDER_DEPTH);
        return (v > top) ? top : v;
    endfunction

endpackage

[hw/rtl/deferred_step_scheduler_core.sv]
// deferred step scheduler: top level with control, cursor, config registers and results
// depends on dss_pkg, dss_chain, dss_marks and assert_macros.svh
//
// Start is taken while busy is low; the next cycle updates the row of
// deferred list cells, the cursor and the attempted marks, and the result
// appears with done high for one cycle right after, while the next item may
// already be taken. There is one result per item and the receiver cannot
// stall it. The list lookup, retire shift and first-eligible pick all ripple
// through the cell row within the update cycle.
// After reset busy stays high while the attempted marks are cleared one per
// cycle.
// Configuration writes are always ready and must only arrive while idle.
`include "assert_macros.svh"

module deferred_step_scheduler_core (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [1:0]                 operation,
    input  logic [dss_pkg::ORD_W-1:0]  ordinal,
    input  logic [dss_pkg::LIM_W-1:0]  bound,
    output logic                       done,
    output logic                       step_valid,
    output logic [dss_pkg::ORD_W-1:0]  step_ordinal,
    output logic                       deferred_hit,
    output logic                       list_full,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic                       cfg_index,
    input  logic [dss_pkg::LIM_W-1:0]  cfg_data
);
    import dss_pkg::*;

    state_t             state_reg, state_next;
    op_t                op_reg;
    logic [ORD_W-1:0]   ord_reg;
    logic [LIM_W-1:0]   bound_reg;
    logic [LIM_W-1:0]   cursor_reg, cursor_next;
    logic [DCNT_W-1:0]  count_reg, count_next;
    logic               done_reg, done_next;
    logic               step_valid_reg, step_valid_next;
    logic [ORD_W-1:0]   step_ordinal_reg, step_ordinal_next;
    logic               deferred_hit_reg, deferred_hit_next;
    logic               list_full_reg, list_full_next;
    logic [LIM_W-1:0]   step_limit_reg;
    logic [LIM_W-1:0]   tracked_count_reg;

    logic               accept;
    logic               exec;
    logic [LIM_W-1:0]   tracked;
    logic [LIM_W-1:0]   limit;
    logic               ord_tracked;
    logic               append_req;
    logic               has_room;
    logic               fwd_ok;
    logic               any_match;
    logic               any_elig;
    logic [ORD_W-1:0]   pick;
    logic               mark_rd;
    logic               mark_set;
    logic [ORD_W-1:0]   mark_addr;
    logic               marks_clearing;
    cell_ctrl_t         ctrl;

    assign exec      = (state_reg == ST_EXEC);
    assign busy      = exec || marks_clearing;
    assign accept    = start && !busy;
    assign cfg_ready = 1'b1;

    assign tracked     = clamp_depth(tracked_count_reg);
    assign limit       = clamp_depth(step_limit_reg);
    assign ord_tracked = {1'b0, ord_reg} < tracked;
    assign append_req  = (op_reg == OP_DEFER)
                      || ((op_reg == OP_DEFER_BELOW) && ({1'b0, ord_reg} < bound_reg));
    assign has_room    = count_reg < DCNT_W'(DEFER_DEPTH);
    assign fwd_ok      = cursor_reg < limit;

    always_comb
    begin
        ctrl.commit      = exec;
        ctrl.is_next     = (op_reg == OP_NEXT);
        ctrl.is_retire   = (op_reg == OP_RETIRE);
        ctrl.do_mark     = (op_reg == OP_DEFER) && ord_tracked;
        ctrl.do_append   = append_req && !any_match && has_room;
        ctrl.append_mark = mark_rd || ((op_reg == OP_DEFER) && ord_tracked);
        ctrl.ord         = ord_reg;
        ctrl.tracked     = tracked;
    end

    dss_chain u_chain (
        .clk       (clk),
        .ctrl      (ctrl),
        .count     (count_reg),
        .any_match (any_match),
        .any_elig  (any_elig),
        .pick      (pick)
    );

    // next marks the picked deferred item, defer marks its own ordinal when it is tracked
    assign mark_set  = exec && (((op_reg == OP_NEXT) && any_elig) || ctrl.do_mark);
    assign mark_addr = (op_reg == OP_NEXT) ? pick : ord_reg;

    // mark of the incoming ordinal is read as the item is taken
    dss_marks u_marks (
        .clk      (clk),
        .rst_n    (rst_n),
        .set_en   (mark_set),
        .set_addr (mark_addr),
        .rd_en    (accept),
        .rd_addr  (ordinal),
        .rd_bit   (mark_rd),
        .clearing (marks_clearing)
    );

    always_comb
    begin
        state_next        = state_reg;
        cursor_next       = cursor_reg;
        count_next        = count_reg;
        done_next         = 1'b0;
        step_valid_next   = step_valid_reg;
        step_ordinal_next = step_ordinal_reg;
        deferred_hit_next = deferred_hit_reg;
        list_full_next    = list_full_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next        = ST_IDLE;
                done_next         = 1'b1;
                step_valid_next   = 1'b0;
                step_ordinal_next = '0;
                deferred_hit_next = 1'b0;
                list_full_next    = append_req && !any_match && !has_room;
                case (op_reg)
                    OP_NEXT:
                    begin
                        if (any_elig)
                        begin
                            step_valid_next   = 1'b1;
                            step_ordinal_next = pick;
                            deferred_hit_next = 1'b1;
                        end
                        else if (fwd_ok)
                        begin
                            step_valid_next   = 1'b1;
                            step_ordinal_next = cursor_reg[ORD_W-1:0];
                            cursor_next       = cursor_reg + LIM_W'(1);
                        end
                    end
                    OP_RETIRE:
                    begin
                        if (any_match)
                        begin
                            count_next = count_reg - DCNT_W'(1);
                        end
                    end
                    default:
                    begin
                        if (ctrl.do_append)
                        begin
                            count_next = count_reg + DCNT_W'(1);
                        end
                    end
                endcase
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            cursor_reg <= '0;
            count_reg  <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cursor_reg <= cursor_next;
            count_reg  <= count_next;
            done_reg   <= done_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_limit_reg    <= '0;
            tracked_count_reg <= LIM_W'(ORDER_DEPTH);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_STEP_LIMIT:    step_limit_reg    <= cfg_data;
                CFG_TRACKED_COUNT: tracked_count_reg <= cfg_data;
                default:           step_limit_reg    <= step_limit_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg    <= op_t'(operation);
            ord_reg   <= ordinal;
            bound_reg <= bound;
        end
        step_valid_reg   <= step_valid_next;
        step_ordinal_reg <= step_ordinal_next;
        deferred_hit_reg <= deferred_hit_next;
        list_full_reg    <= list_full_next;
    end

    assign done         = done_reg;
    assign step_valid   = step_valid_reg;
    assign step_ordinal = step_ordinal_reg;
    assign deferred_hit = deferred_hit_reg;
    assign list_full    = list_full_reg;

    `ASSERT_PROP(a_done_after_exec, clk, rst_n, exec |=> done)
    `ASSERT_NEVER(a_done_while_busy, clk, rst_n, done && busy)
    `ASSERT_NEVER(a_count_overflow, clk, rst_n, count_reg > DCNT_W'(DEFER_DEPTH))
    `ASSERT_NEVER(a_cursor_overflow, clk, rst_n, cursor_reg > LIM_W'(ORDER_DEPTH))
    `ASSERT_PROP(a_deferred_is_valid, clk, rst_n, (done && deferred_hit) |-> step_valid)

endmodule

[hw/rtl/dss_cell.sv]
// one slot of the deferred list: ordinal, cached attempted mark, search and shift links
// depends on dss_pkg
module dss_cell (
    input  logic                      clk,
    input  dss_pkg::cell_ctrl_t       ctrl,
    input  logic                      occupied,
    input  logic                      tail,
    input  logic [dss_pkg::ORD_W-1:0] right_entry,
    input  logic                      right_mark,
    input  logic                      shift_in,
    input  logic                      found_in,
    output logic [dss_pkg::ORD_W-1:0] entry,
    output logic                      mark,
    output logic                      shift_out,
    output logic                      found_out,
    output logic                      take
);
    import dss_pkg::*;

    logic [ORD_W-1:0] entry_reg;
    logic [ORD_W-1:0] entry_next;
    logic             mark_reg;
    logic             mark_next;
    logic             match;
    logic             elig;

    assign match     = occupied && (entry_reg == ctrl.ord);
    assign elig      = occupied && ({1'b0, entry_reg} < ctrl.tracked) && !mark_reg;
    assign shift_out = shift_in | match;
    assign found_out = found_in | elig;
    assign take      = ctrl.is_next && elig && !found_in;

    always_comb
    begin
        entry_next = entry_reg;
        mark_next  = mark_reg;
        if (ctrl.commit)
        begin
            if (ctrl.is_retire && (shift_in || match))
            begin
                // close the gap left by the retired item
                entry_next = right_entry;
                mark_next  = right_mark;
            end
            else if (tail && ctrl.do_append)
            begin
                entry_next = ctrl.ord;
                mark_next  = ctrl.append_mark;
            end
            else if (take || (ctrl.do_mark && match))
            begin
                mark_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
        mark_reg  <= mark_next;
    end

    assign entry = entry_reg;
    assign mark  = mark_reg;

endmodule

[hw/rtl/dss_chain.sv]
// row of deferred list cells with ripple links for lookup, retire shift and priority pick
// depends on dss_pkg and dss_cell
module dss_chain (
    input  logic                       clk,
    input  dss_pkg::cell_ctrl_t        ctrl,
    input  logic [dss_pkg::DCNT_W-1:0] count,
    output logic                       any_match,
    output logic                       any_elig,
    output logic [dss_pkg::ORD_W-1:0]  pick
);
    import dss_pkg::*;

    logic [ORD_W-1:0]   entry_w [DEFER_DEPTH];
    logic [DEFER_DEPTH-1:0] mark_w;
    logic [DEFER_DEPTH:0]   shift_w;
    logic [DEFER_DEPTH:0]   found_w;
    logic [DEFER_DEPTH-1:0] take_w;

    assign shift_w[0] = 1'b0;
    assign found_w[0] = 1'b0;

    for (genvar i = 0; i < DEFER_DEPTH; i++)
    begin : g_cell
        logic [ORD_W-1:0] right_entry;
        logic             right_mark;

        if (i == DEFER_DEPTH - 1)
        begin : g_last
            // last slot has no right neighbor; count drops so its value is dead
            assign right_entry = entry_w[i];
            assign right_mark  = mark_w[i];
        end
        else
        begin : g_mid
            assign right_entry = entry_w[i+1];
            assign right_mark  = mark_w[i+1];
        end

        dss_cell u_cell (
            .clk         (clk),
            .ctrl        (ctrl),
            .occupied    (DCNT_W'(i) < count),
            .tail        (DCNT_W'(i) == count),
            .right_entry (right_entry),
            .right_mark  (right_mark),
            .shift_in    (shift_w[i]),
            .found_in    (found_w[i]),
            .entry       (entry_w[i]),
            .mark        (mark_w[i]),
            .shift_out   (shift_w[i+1]),
            .found_out   (found_w[i+1]),
            .take        (take_w[i])
        );
    end

    assign any_match = shift_w[DEFER_DEPTH];
    assign any_elig  = found_w[DEFER_DEPTH];

    // take is one-hot, so an or of the gated entries selects the winner
    always_comb
    begin
        pick = '0;
        for (int i = 0; i < DEFER_DEPTH; i++)
        begin
            pick = pick | (entry_w[i] & {ORD_W{take_w[i]}});
        end
    end

endmodule

[hw/rtl/dss_marks.sv]
// attempted mark per ordinal in a one-bit memory, one set port and one registered read port
// depends on dss_pkg; after reset a clearing pass zeroes every mark
module dss_marks (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      set_en,
    input  logic [dss_pkg::ORD_W-1:0] set_addr,
    input  logic                      rd_en,
    input  logic [dss_pkg::ORD_W-1:0] rd_addr,
    output logic                      rd_bit,
    output logic                      clearing
);
    import dss_pkg::*;

    logic             marks_mem [ORDER_DEPTH];
    logic             rd_bit_reg;
    logic             clear_reg;
    logic             clear_next;
    logic [ORD_W-1:0] clear_addr_reg;
    logic [ORD_W-1:0] clear_addr_next;

    always_comb
    begin
        clear_next      = clear_reg;
        clear_addr_next = clear_addr_reg;
        if (clear_reg)
        begin
            clear_addr_next = clear_addr_reg + ORD_W'(1);
            if (clear_addr_reg == ORD_W'(ORDER_DEPTH - 1))
            begin
                clear_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_reg      <= 1'b1;
            clear_addr_reg <= '0;
        end
        else
        begin
            clear_reg      <= clear_next;
            clear_addr_reg <= clear_addr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (clear_reg)
        begin
            marks_mem[clear_addr_reg] <= 1'b0;
        end
        else if (set_en)
        begin
            marks_mem[set_addr] <= 1'b1;
        end
        if (rd_en)
        begin
            rd_bit_reg <= marks_mem[rd_addr];
        end
    end

    assign rd_bit   = rd_bit_reg;
    assign clearing = clear_reg;

endmodule
